@@ hw/rtl/clipped_color_key_sprite_blit_assert.svh @@
// Assertion macros shared by the sprite blitter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CLIPPED_COLOR_KEY_SPRITE_BLIT_ASSERT_SVH
`define CLIPPED_COLOR_KEY_SPRITE_BLIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCKSB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCKSB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ccksb_pkg.sv @@
// Package of the sprite blitter: field widths, defaults, register codes and shared types.
// Depends on nothing; used by every module of the block.
`default_nettype none

package ccksb_pkg;

  // Default geometry.
  localparam int unsigned SCREEN_WIDTH_DEF   = 640;
  localparam int unsigned SCREEN_HEIGHT_DEF  = 480;
  localparam int unsigned MAX_SPRITE_DIM_DEF = 512;
  localparam int unsigned QUEUE_DEPTH_DEF    = 4;

  // Fixed field widths.
  localparam int unsigned TEXEL_W      = 8;
  localparam int unsigned ADDR_W       = 19;
  localparam int unsigned POS_W        = 11;
  localparam int unsigned SPRITE_DIM_W = 10;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 11;

  // Screen position sums: signed position plus a sprite counter.
  localparam int unsigned POS_SUM_W = POS_W + 1;
  // Effective sprite dimension after clamping (holds up to 2047).
  localparam int unsigned DIM_CMP_W = SPRITE_DIM_W + 1;

  localparam logic [TEXEL_W-1:0]      SHADE_OFFSET    = 8'd128;
  localparam logic [SPRITE_DIM_W-1:0] SPRITE_DIM_RST  = 10'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_X         = 3'd0,
    REG_POS_Y         = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_SHADE_MODE    = 3'd4
  } ccksb_reg_e;

  // Occupancy flags of the queue between front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } ccksb_qstat_t;

endpackage

`default_nettype wire

@@ hw/rtl/ccksb_front.sv @@
// Front end: configuration registers, sprite counters, and classification of each texel.
// Depends on ccksb_pkg; feeds visible pixels into ccksb_queue.
`default_nettype none

module ccksb_front #(
  parameter int unsigned SCREEN_WIDTH   = ccksb_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT  = ccksb_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned MAX_SPRITE_DIM = ccksb_pkg::MAX_SPRITE_DIM_DEF,
  parameter int unsigned XW             = $clog2(SCREEN_WIDTH),
  parameter int unsigned YW             = $clog2(SCREEN_HEIGHT),
  parameter int unsigned EntW           = XW + YW + ccksb_pkg::TEXEL_W
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [ccksb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [ccksb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [ccksb_pkg::TEXEL_W-1:0]       texel_i,
  input  wire ccksb_pkg::ccksb_qstat_t             qstat_i,
  output logic                                     push_o,
  output logic [EntW-1:0]                          push_data_o
);
  import ccksb_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SPRITE_DIM);
  localparam int unsigned CmpW = POS_SUM_W + 1;

  logic [POS_W-1:0]        pos_x_q, pos_y_q;
  logic [SPRITE_DIM_W-1:0] spr_w_q, spr_h_q;
  logic                    shade_q;
  logic [CntW-1:0]         col_q, col_d, row_q, row_d;

  logic                    accept;
  logic [POS_SUM_W-1:0]    sx, sy;
  logic                    x_vis, y_vis;
  logic [DIM_CMP_W-1:0]    eff_w, eff_h;
  logic [CntW:0]           col_inc, row_inc;
  logic                    col_last, row_last;
  logic [TEXEL_W-1:0]      pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      spr_w_q <= SPRITE_DIM_RST;
      spr_h_q <= SPRITE_DIM_RST;
      shade_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POS_X:         pos_x_q <= cfg_wdata_i[POS_W-1:0];
        REG_POS_Y:         pos_y_q <= cfg_wdata_i[POS_W-1:0];
        REG_SPRITE_WIDTH:  spr_w_q <= cfg_wdata_i[SPRITE_DIM_W-1:0];
        REG_SPRITE_HEIGHT: spr_h_q <= cfg_wdata_i[SPRITE_DIM_W-1:0];
        REG_SHADE_MODE:    shade_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // Screen position: sign-extended origin plus the zero-extended counter.
  always_comb begin
    sx = {pos_x_q[POS_W-1], pos_x_q} + POS_SUM_W'(col_q);
    sy = {pos_y_q[POS_W-1], pos_y_q} + POS_SUM_W'(row_q);
    x_vis = !sx[POS_SUM_W-1] && (CmpW'(sx) < CmpW'(SCREEN_WIDTH));
    y_vis = !sy[POS_SUM_W-1] && (CmpW'(sy) < CmpW'(SCREEN_HEIGHT));
  end

  // A dimension of zero behaves as one; anything above the limit is clamped.
  always_comb begin
    if (spr_w_q == '0) begin
      eff_w = DIM_CMP_W'(1);
    end else if (DIM_CMP_W'(spr_w_q) > DIM_CMP_W'(MAX_SPRITE_DIM)) begin
      eff_w = DIM_CMP_W'(MAX_SPRITE_DIM);
    end else begin
      eff_w = DIM_CMP_W'(spr_w_q);
    end
    if (spr_h_q == '0) begin
      eff_h = DIM_CMP_W'(1);
    end else if (DIM_CMP_W'(spr_h_q) > DIM_CMP_W'(MAX_SPRITE_DIM)) begin
      eff_h = DIM_CMP_W'(MAX_SPRITE_DIM);
    end else begin
      eff_h = DIM_CMP_W'(spr_h_q);
    end
  end

  // Counters already past a newly written limit wrap on their next advance.
  always_comb begin
    col_inc  = {1'b0, col_q} + 1'b1;
    row_inc  = {1'b0, row_q} + 1'b1;
    col_last = DIM_CMP_W'(col_inc) >= eff_w;
    row_last = DIM_CMP_W'(row_inc) >= eff_h;
    col_d    = col_q;
    row_d    = row_q;
    if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_inc[CntW-1:0];
      end else begin
        col_d = col_inc[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Transparency is judged on the incoming texel, before shading.
  assign pix         = shade_q ? texel_i + SHADE_OFFSET : texel_i;
  assign push_o      = accept && (texel_i != '0) && x_vis && y_vis;
  assign push_data_o = {sy[YW-1:0], sx[XW-1:0], pix};

endmodule

`default_nettype wire

@@ hw/rtl/ccksb_queue.sv @@
// Short register queue that decouples classification from address generation.
// Depends on ccksb_pkg and the assertion macro header.
`default_nettype none
`include "clipped_color_key_sprite_blit_assert.svh"

module ccksb_queue #(
  parameter int unsigned Depth = ccksb_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned EntW  = 27
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire logic [EntW-1:0]         push_data_i,
  input  wire logic                    pop_i,
  output logic [EntW-1:0]              head_o,
  output ccksb_pkg::ccksb_qstat_t      qstat_o
);
  import ccksb_pkg::*;

  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  logic [EntW-1:0]   ent_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o        = ent_q[rd_ptr_q];
  assign qstat_o.full  = (count_q == CountW'(Depth));
  assign qstat_o.empty = (count_q == '0);

  `CCKSB_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i, !qstat_o.full, "push into full queue")
  `CCKSB_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop_i, !qstat_o.empty, "pop from empty queue")
  `CCKSB_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CountW'(Depth), "count overrun")
  `CCKSB_ASSERT_NXT(a_count_inc, clk_i, rst_ni, push_i && !pop_i, count_q == CountW'($past(count_q) + 1'b1), "count did not grow")

endmodule

`default_nettype wire

@@ hw/rtl/ccksb_back.sv @@
// Back end: turns queued screen coordinates into framebuffer writes behind an output register.
// Depends on ccksb_pkg; drains ccksb_queue.
`default_nettype none

module ccksb_back #(
  parameter int unsigned SCREEN_WIDTH  = ccksb_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = ccksb_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned XW            = $clog2(SCREEN_WIDTH),
  parameter int unsigned YW            = $clog2(SCREEN_HEIGHT),
  parameter int unsigned EntW          = XW + YW + ccksb_pkg::TEXEL_W
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [EntW-1:0]                  head_i,
  input  wire ccksb_pkg::ccksb_qstat_t          qstat_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [ccksb_pkg::ADDR_W-1:0]          write_address_o,
  output logic [ccksb_pkg::TEXEL_W-1:0]         write_data_o
);
  import ccksb_pkg::*;

  localparam int unsigned ProdW = XW + YW;

  logic [XW-1:0]        hx;
  logic [YW-1:0]        hy;
  logic [TEXEL_W-1:0]   hdata;
  logic [ProdW-1:0]     lin;
  logic                 load;
  logic                 out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]    addr_q;
  logic [TEXEL_W-1:0]   data_q;

  assign {hy, hx, hdata} = head_i;

  // Row times screen width plus column; the product stays below 2**ProdW.
  assign lin = ProdW'(hy) * ProdW'(SCREEN_WIDTH) + ProdW'(hx);

  // The output register takes a new entry whenever it is empty or being drained.
  assign load        = !out_valid_q || !out_stall_i;
  assign pop_o       = load && !qstat_i.empty;
  assign out_valid_d = load ? !qstat_i.empty : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      addr_q <= ADDR_W'(lin);
      data_q <= hdata;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_address_o = addr_q;
  assign write_data_o    = data_q;

endmodule

`default_nettype wire

@@ hw/rtl/clipped_color_key_sprite_blit.sv @@
// Color-key sprite blitter with screen clipping: one texel accepted per cycle while
// in_stall_o is low. A visible accepted texel is stored in the queue, then in the output
// register. Throughput: one texel per cycle, set by the combinational front classifier
// and the queue drain; out_stall_i holds the output register and the queue absorbs up to
// its depth. Reset (asynchronous, active low) clears counters, queue and output valid, and
// loads register defaults; there is no clearing pass.
`default_nettype none

module clipped_color_key_sprite_blit #(
  parameter int unsigned SCREEN_WIDTH   = ccksb_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT  = ccksb_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned MAX_SPRITE_DIM = ccksb_pkg::MAX_SPRITE_DIM_DEF,
  parameter int unsigned QUEUE_DEPTH    = ccksb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ccksb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ccksb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [ccksb_pkg::TEXEL_W-1:0]     texel_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [ccksb_pkg::ADDR_W-1:0]           write_address_o,
  output logic [ccksb_pkg::TEXEL_W-1:0]          write_data_o
);
  import ccksb_pkg::*;

  localparam int unsigned XW   = $clog2(SCREEN_WIDTH);
  localparam int unsigned YW   = $clog2(SCREEN_HEIGHT);
  localparam int unsigned EntW = XW + YW + TEXEL_W;

  ccksb_qstat_t    qstat;
  logic            push, pop;
  logic [EntW-1:0] push_data, head;

  ccksb_front #(
    .SCREEN_WIDTH   (SCREEN_WIDTH),
    .SCREEN_HEIGHT  (SCREEN_HEIGHT),
    .MAX_SPRITE_DIM (MAX_SPRITE_DIM),
    .XW             (XW),
    .YW             (YW),
    .EntW           (EntW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .texel_i     (texel_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ccksb_queue #(
    .Depth (QUEUE_DEPTH),
    .EntW  (EntW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .qstat_o     (qstat)
  );

  ccksb_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .XW            (XW),
    .YW            (YW),
    .EntW          (EntW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .qstat_i         (qstat),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o)
  );

endmodule

`default_nettype wire

@@ bench/clipped_color_key_sprite_blit_tb.sv @@
// Self-checking testbench for the clipped color-key sprite blitter.
// It needs ccksb_pkg and the clipped_color_key_sprite_blit RTL. It predicts every
// framebuffer write and runs directed clipping cases and randomly idled sprite streams.
module clipped_color_key_sprite_blit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ccksb_pkg::*;

  localparam int SCREEN_W         = SCREEN_WIDTH_DEF;
  localparam int SCREEN_H         = SCREEN_HEIGHT_DEF;
  localparam int MAX_DIM          = MAX_SPRITE_DIM_DEF;
  localparam int DRAIN_CYCLES     = 8;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETUPS_PER_PHASE = 6;
  localparam int TEXELS_PER_SETUP = 52;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [TEXEL_W-1:0] data;
  } fb_write_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = REG_POS_X;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic [TEXEL_W-1:0]    texel_i     = '0;
  logic                  out_stall_i = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [ADDR_W-1:0]     write_address_o;
  logic [TEXEL_W-1:0]    write_data_o;

  // Predicted blitter state: registers and the raster counters.
  logic signed [POS_W-1:0] blit_pos_x  = '0;
  logic signed [POS_W-1:0] blit_pos_y  = '0;
  logic [SPRITE_DIM_W-1:0] blit_width  = SPRITE_DIM_RST;
  logic [SPRITE_DIM_W-1:0] blit_height = SPRITE_DIM_RST;
  logic                    blit_shade  = 1'b0;
  int                      blit_col    = 0;
  int                      blit_row    = 0;

  fb_write_t pending_writes[$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int          cycle_count     = 0;
  int          mismatches      = 0;
  int          texels_sent     = 0;
  int          writes_checked  = 0;
  int          sprite_setups   = 0;

  clipped_color_key_sprite_blit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .texel_i         (texel_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d writes outstanding.",
               cycle_count, pending_writes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int clamp_dim(input logic [SPRITE_DIM_W-1:0] d);
    if (d == 0) return 1;
    if (int'(d) > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  // Places one texel on the screen and advances the raster counters.
  // Returns 1 when the texel produces a framebuffer write.
  function automatic bit place_texel(input logic [TEXEL_W-1:0] t, output fb_write_t w);
    int sx;
    int sy;
    int lin;
    bit shown;
    sx = int'(blit_pos_x) + blit_col;
    sy = int'(blit_pos_y) + blit_row;
    shown = (t != 0) && sx >= 0 && sx < SCREEN_W && sy >= 0 && sy < SCREEN_H;
    lin = shown ? sy * SCREEN_W + sx : 0;
    w.addr = lin[ADDR_W-1:0];
    w.data = blit_shade ? t + SHADE_OFFSET : t;
    // Counters left beyond a shrunken sprite wrap on their next advance.
    if (blit_col + 1 >= clamp_dim(blit_width)) begin
      blit_col = 0;
      if (blit_row + 1 >= clamp_dim(blit_height)) blit_row = 0;
      else blit_row++;
    end else begin
      blit_col++;
    end
    return shown;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("Mismatch at %0t: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    fb_write_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      writes_checked++;
      if (pending_writes.size() == 0) begin
        flag_mismatch($sformatf("unexpected write addr %0d data 0x%02h",
                                write_address_o, write_data_o));
      end else begin
        want = pending_writes.pop_front();
        if (write_address_o !== want.addr || write_data_o !== want.data)
          flag_mismatch($sformatf("expected addr %0d data 0x%02h, got addr %0d data 0x%02h",
                                  want.addr, want.data, write_address_o, write_data_o));
      end
    end
  end

  task automatic write_reg(input ccksb_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_POS_X:         blit_pos_x = value;
      REG_POS_Y:         blit_pos_y = value;
      REG_SPRITE_WIDTH:  blit_width = value[SPRITE_DIM_W-1:0];
      REG_SPRITE_HEIGHT: blit_height = value[SPRITE_DIM_W-1:0];
      REG_SHADE_MODE:    blit_shade = value[0];
      default: ;
    endcase
  endtask

  task automatic setup_sprite(input int px, input int py, input int w, input int h,
                              input int shade);
    write_reg(REG_POS_X, CFG_DATA_W'(px));
    write_reg(REG_POS_Y, CFG_DATA_W'(py));
    write_reg(REG_SPRITE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_SPRITE_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_SHADE_MODE, CFG_DATA_W'(shade));
    cfg_we_i <= 1'b0;
    sprite_setups++;
  endtask

  // Holds the sender off until every predicted write has come out, then lets
  // transparent or clipped texels still in the pipe settle.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_texel(input logic [TEXEL_W-1:0] t);
    fb_write_t w;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      texel_i    <= TEXEL_W'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    texel_i    <= t;
    do @(posedge clk_i); while (in_stall_o);
    if (place_texel(t, w)) pending_writes.push_back(w);
    texels_sent++;
  endtask

  function automatic int random_dim();
    case ($urandom_range(0, 19))
      12, 13:  return 0;
      14, 15:  return MAX_DIM;
      16, 17:  return $urandom_range(MAX_DIM + 1, 1023);
      18, 19:  return $urandom_range(21, MAX_DIM - 1);
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  function automatic logic [TEXEL_W-1:0] random_texel();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: return 8'h00;
      5:             return 8'h80;
      6:             return 8'hFF;
      7:             return 8'h01;
      default:       return TEXEL_W'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic random_sprite_setup();
    int px;
    int py;
    int w;
    int h;
    // Mostly near the screen so that clipping edges are crossed often.
    px = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 720)) - 40
                                    : int'($urandom_range(0, 2047));
    py = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 540)) - 40
                                    : int'($urandom_range(0, 2047));
    // Bit 10 of the data word lies above the size registers and must be ignored.
    w = random_dim() | (int'($urandom_range(0, 1)) << SPRITE_DIM_W);
    h = random_dim() | (int'($urandom_range(0, 1)) << SPRITE_DIM_W);
    setup_sprite(px, py, w, h, int'($urandom_range(0, 2047)));
  endtask

  task automatic run_random_blits();
    repeat (SETUPS_PER_PHASE) begin
      wait_until_drained();
      random_sprite_setup();
      repeat (TEXELS_PER_SETUP) begin
        if ($urandom_range(0, 49) == 0) wait_until_drained();
        send_texel(random_texel());
      end
    end
  endtask

  task automatic test_color_key_and_clipping();
    logic [TEXEL_W-1:0] keyed[5]  = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F};
    logic [TEXEL_W-1:0] corner[10] = '{8'h5A, 8'h80, 8'hFF, 8'h01, 8'h33,
                                       8'h44, 8'h55, 8'h01, 8'h7F, 8'h02};
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    // Reset geometry: transparent key and value extremes on the top row.
    foreach (keyed[i]) send_texel(keyed[i]);
    wait_until_drained();
    // A 3x3 shaded sprite over the bottom-right corner; the column counter is
    // already past the new width, so the first texel wraps the raster.
    setup_sprite(SCREEN_W - 2, SCREEN_H - 2, 3, 3, 1);
    foreach (corner[i]) send_texel(corner[i]);
  endtask

  task automatic test_register_extremes();
    wait_until_drained();
    // Most negative position with zero sizes, which act as a single texel.
    setup_sprite(-1024, -1024, 0, 0, 0);
    send_texel(8'hFF);
    send_texel(8'h01);
    wait_until_drained();
    // Most positive position and oversize dimensions, clamped internally.
    setup_sprite(1023, 1023, 1023, 1023, 1);
    send_texel(8'h80);
    wait_until_drained();
    // Sprite hanging off the top-left corner: only the texel at the screen origin lands.
    setup_sprite(-1, -1, 2, 2, 0);
    repeat (4) send_texel(8'hC3);
    wait_until_drained();
    setup_sprite(0, 0, MAX_DIM, MAX_DIM, 0);
    send_texel(8'h01);
    send_texel(8'hFE);
  endtask

  task automatic test_full_rate();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    run_random_blits();
  endtask

  task automatic test_sender_gaps();
    sender_idle_pct = 73;
    recv_stall_pct  = 0;
    run_random_blits();
  endtask

  task automatic test_receiver_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 73;
    run_random_blits();
  endtask

  task automatic test_mixed_idling();
    sender_idle_pct = 13;
    recv_stall_pct  = 13;
    run_random_blits();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_color_key_and_clipping();
    test_register_extremes();
    test_full_rate();
    test_sender_gaps();
    test_receiver_backpressure();
    test_mixed_idling();
    wait_until_drained();
    $display("Blitted %0d texels across %0d sprite setups with clipping, keying and shading;",
             texels_sent, sprite_setups);
    $display("%0d framebuffer writes checked, %0d mismatches.", writes_checked, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
